// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the queue core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition cons must hold in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/tsq_pkg.sv =====
// ============================================================================
// tsq_pkg
// Types and constants shared by the two-stack queue core.
// ============================================================================
package tsq_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } tsq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } tsq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_XFER,
    S_LAST
  } tsq_state_t;

  typedef struct packed {
    tsq_op_t                   opcode;
    logic signed [DATA_W-1:0]  value;
  } tsq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    tsq_status_t               status;
    logic                      queue_empty;
  } tsq_rsp_t;

endpackage

// ===== rtl/core/two_stack_queue_unit.sv =====
// Enqueue and dequeue-on-empty give their result word in the cycle after accept;
//   a dequeue with the output stack loaded reads it through its read port in S_POP.
// A dequeue that refills the output stack moves the intake entries in S_XFER,
//   one entry per cycle through the intake read port, and returns the oldest in S_LAST.
// A new word is accepted in the cycle after a result is loaded only if rsp_ready is high.
// Reset clears both counts and the control state; stack memories are not cleared.
// ============================================================================
// two_stack_queue_unit
// FIFO queue built from an intake stack and an output stack in two RAMs.
// ============================================================================
`include "assert_macros.svh"

module two_stack_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tsq_pkg::tsq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tsq_pkg::tsq_rsp_t rsp
);
  import tsq_pkg::*;

  tsq_state_t        state;
  tsq_state_t        state_next;
  logic [CNT_W-1:0]  in_count;
  logic [CNT_W-1:0]  out_count;
  logic [ADDR_W-1:0] rd_idx;
  logic [ADDR_W-1:0] wr_idx;
  logic              rd_pend;

  logic              accept;
  logic              in_full;
  logic              out_has;
  logic              q_empty;

  logic              in_we;
  logic [ADDR_W-1:0] in_waddr;
  logic [ADDR_W-1:0] in_raddr;
  logic [DATA_W-1:0] in_rdata;
  logic              out_we;
  logic [ADDR_W-1:0] out_raddr;
  logic [DATA_W-1:0] out_rdata;

  logic              load_rsp;
  tsq_rsp_t          rsp_next;

  assign accept  = req_valid && req_ready;
  assign in_full = (in_count == CNT_W'(STACK_DEPTH));
  assign out_has = (out_count != '0);
  assign q_empty = (in_count == '0) && !out_has;

  // ---- storage ----
  tsq_stack_mem u_intake (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (req.value),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  tsq_stack_mem u_output (
    .clk   (clk),
    .we    (out_we),
    .waddr (wr_idx),
    .wdata (in_rdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.opcode == OP_DEQ) begin
          if (out_has) begin
            state_next = S_POP;
          end else if (in_count != '0) begin
            state_next = S_XFER;
          end
        end
      end
      S_POP:  state_next = S_IDLE;
      S_XFER: begin
        if (rd_idx == '0) begin
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: handshake, memory controls, result word
  always_comb begin
    req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
    in_we     = 1'b0;
    in_waddr  = in_count[ADDR_W-1:0];
    in_raddr  = rd_idx;
    out_we    = 1'b0;
    out_raddr = ADDR_W'(out_count - 1'b1);
    load_rsp  = 1'b0;
    rsp_next  = '{data: '0, status: ST_OK, queue_empty: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.opcode == OP_ENQ) begin
            load_rsp = 1'b1;
            if (in_full) begin
              rsp_next.status      = ST_FULL;
              rsp_next.queue_empty = q_empty;
            end else begin
              in_we = 1'b1;
            end
          end else if (q_empty) begin
            load_rsp             = 1'b1;
            rsp_next.data        = '1;
            rsp_next.status      = ST_EMPTY;
            rsp_next.queue_empty = 1'b1;
          end
        end
      end
      S_POP: begin
        load_rsp             = 1'b1;
        rsp_next.data        = out_rdata;
        rsp_next.queue_empty = (out_count == CNT_W'(1)) && (in_count == '0);
      end
      S_XFER: begin
        out_we = rd_pend;
      end
      S_LAST: begin
        // last read is the oldest intake entry: it goes straight out
        out_we               = 1'b1;
        load_rsp             = 1'b1;
        rsp_next.data        = in_rdata;
        rsp_next.queue_empty = (in_count == CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          rd_idx  <= ADDR_W'(in_count - 1'b1);
          wr_idx  <= '0;
          rd_pend <= 1'b0;
          if (in_we) begin
            in_count <= in_count + 1'b1;
          end
        end
        S_POP: begin
          out_count <= out_count - 1'b1;
        end
        S_XFER: begin
          rd_pend <= 1'b1;
          rd_idx  <= rd_idx - 1'b1;
          if (rd_pend) begin
            wr_idx <= wr_idx + 1'b1;
          end
        end
        S_LAST: begin
          out_count <= in_count - 1'b1;
          in_count  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  // ---- assertions ----
  `ASSERT_SAME(a_in_bound, clk, rst, 1'b1, in_count <= CNT_W'(STACK_DEPTH))
  `ASSERT_SAME(a_xfer_out_empty, clk, rst, state == S_XFER || state == S_LAST, out_count == '0)
  `ASSERT_SAME(a_full_holds, clk, rst, rsp_valid && rsp.status == ST_FULL, in_full)
  `ASSERT_NEXT(a_pop_start, clk, rst, accept && req.opcode == OP_DEQ && out_has, state == S_POP)

endmodule

// ===== rtl/core/tsq_stack_mem.sv =====
// ============================================================================
// tsq_stack_mem
// One stack's storage: one write port, one read port, registered read data.
// ============================================================================
module tsq_stack_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tsq_pkg::ADDR_W-1:0]  waddr,
  input  logic [tsq_pkg::DATA_W-1:0]  wdata,
  input  logic [tsq_pkg::ADDR_W-1:0]  raddr,
  output logic [tsq_pkg::DATA_W-1:0]  rdata
);
  import tsq_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/tsq_order_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tsq_order_checker
// Watches both word channels of the two-stack queue, keeps its own model of
// the intake and output stacks, and compares every response word, field by
// field, against the oldest predicted one. Reports a running failure count.
// ============================================================================
module tsq_order_checker
  import tsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  tsq_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  tsq_rsp_t rsp,
  output int       fail_count,
  output int       open_count
);

  // Model copy of the two stacks
  logic [DATA_W-1:0] intake_mem [STACK_DEPTH];
  logic [DATA_W-1:0] output_mem [STACK_DEPTH];
  int                intake_fill;
  int                output_fill;

  tsq_rsp_t          due_rsp [$];
  int                errs = 0;

  // Apply one request word to the model and return the response it should give
  function automatic tsq_rsp_t queue_outcome(tsq_req_t w);
    tsq_rsp_t r;
    int       k;
    r.data   = '0;
    r.status = ST_OK;
    if (w.opcode == OP_ENQ) begin
      if (intake_fill >= STACK_DEPTH) begin
        r.status = ST_FULL;   // dropped, state untouched
      end else begin
        intake_mem[intake_fill] = w.value;
        intake_fill++;
      end
    end else begin
      // refill only when the output stack ran dry; oldest entry lands on top
      if (output_fill == 0) begin
        for (k = 0; k < intake_fill; k++)
          output_mem[k] = intake_mem[intake_fill - 1 - k];
        output_fill = intake_fill;
        intake_fill = 0;
      end
      if (output_fill == 0) begin
        r.data   = '1;
        r.status = ST_EMPTY;
      end else begin
        output_fill--;
        r.data = output_mem[output_fill];
      end
    end
    r.queue_empty = (intake_fill == 0) && (output_fill == 0);
    return r;
  endfunction

  // Response side first: a word accepted now belongs to an earlier request
  always @(posedge clk) begin
    tsq_rsp_t want;
    if (rst) begin
      intake_fill = 0;
      output_fill = 0;
      due_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          $error("response word with nothing pending: data %h status %0d", rsp.data,
                 rsp.status);
          errs++;
        end else begin
          want = due_rsp.pop_front();
          if (rsp.data !== want.data) begin
            $error("data mismatch: expected %h, got %h", want.data, rsp.data);
            errs++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.queue_empty !== want.queue_empty) begin
            $error("queue_empty mismatch: expected %0b, got %0b", want.queue_empty,
                   rsp.queue_empty);
            errs++;
          end
        end
      end
      if (req_valid && req_ready)
        due_rsp.push_back(queue_outcome(req));
    end
    fail_count <= errs;
    open_count <= due_rsp.size();
  end

endmodule

// ===== tb/sv/two_stack_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// two_stack_queue_unit_test
// Drives request words into the two-stack queue with random idle cycles on
// both channels: a directed opening, a mixed random run, a fill past the
// intake limit, then a dequeue-heavy drain. The checker does all comparing.
// ============================================================================
module two_stack_queue_unit_test;
  import tsq_pkg::*;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_ready = 1'b0;
  tsq_req_t req       = '0;
  logic     req_ready;
  logic     rsp_valid;
  tsq_rsp_t rsp;
  int       fail_count;
  int       open_count;
  bit       steady    = 1'b0;   // no idling on either side while set

  two_stack_queue_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  tsq_order_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls about a third of the time
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Mostly full-range values, with the extremes now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Send one word; valid is only dropped when an idle gap is taken
  task automatic push_word(input tsq_op_t op, input logic [DATA_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 33) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, value: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, extremes, refill, second refill, empty again
    push_word(OP_DEQ, $urandom);
    push_word(OP_ENQ, 32'h8000_0000);
    push_word(OP_ENQ, 32'h7FFF_FFFF);
    push_word(OP_ENQ, 32'h0000_0000);
    push_word(OP_ENQ, 32'hFFFF_FFFF);
    push_word(OP_ENQ, 32'h0000_0001);
    push_word(OP_DEQ, $urandom);
    push_word(OP_ENQ, 32'h5555_5555);
    push_word(OP_ENQ, 32'hAAAA_AAAA);
    repeat (4) push_word(OP_DEQ, $urandom);
    push_word(OP_DEQ, $urandom);
    push_word(OP_DEQ, $urandom);
    push_word(OP_DEQ, $urandom);
    push_word(OP_ENQ, 32'h0000_0007);
    push_word(OP_DEQ, 32'hFFFF_FFFF);
    push_word(OP_DEQ, 32'h0000_0000);

    // Mixed random traffic, slightly enqueue-leaning
    repeat (300)
      push_word(($urandom_range(0, 99) < 55) ? OP_ENQ : OP_DEQ, pick_value());

    // Fill the intake stack past its limit; the first stretch runs with no
    // idling on either side
    push_word(OP_DEQ, $urandom);
    repeat (3) push_word(OP_ENQ, pick_value());
    push_word(OP_DEQ, $urandom);
    steady = 1'b1;
    for (n = 0; n < STACK_DEPTH + 6; n++) begin
      if (n == 400)
        steady = 1'b0;
      push_word(OP_ENQ, pick_value());
    end

    // Drain: full-depth refill, then dequeue-heavy traffic
    repeat (500)
      push_word(($urandom_range(0, 99) < 25) ? OP_ENQ : OP_DEQ, pick_value());

    req_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== two_stack_queue_unit.f =====
+incdir+rtl/core
rtl/core/tsq_pkg.sv
rtl/core/tsq_stack_mem.sv
rtl/core/two_stack_queue_unit.sv
tb/sv/tsq_order_checker.sv
tb/sv/two_stack_queue_unit_test.sv
